>>> rtl/vhcd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the voxel hash centroid downsampler
// no dependencies
package vhcd_pkg;

	localparam int TblSize  = 1024;
	localparam int TblAw    = $clog2(TblSize);
	localparam int QDepth   = 4;
	localparam int QAw      = $clog2(QDepth);
	localparam int DivSteps = 48;

	localparam logic [31:0] HashPx   = 32'd73856093;
	localparam logic [31:0] HashPy   = 32'd19349663;
	localparam logic [31:0] HashPz   = 32'd83492791;
	localparam logic [15:0] CountMax = 16'hFFFF;
	localparam logic [23:0] InvLeafRst = 24'd655360;

	localparam logic [1:0] CfgInvX = 2'd0;
	localparam logic [1:0] CfgInvY = 2'd1;
	localparam logic [1:0] CfgInvZ = 2'd2;

	localparam logic OpAdd   = 1'b0;
	localparam logic OpDrain = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] x_coord;
		logic [31:0] y_coord;
		logic [31:0] z_coord;
		logic [15:0] intensity_in;
	} item_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] mean_x;
		logic [31:0] mean_y;
		logic [31:0] mean_z;
		logic [15:0] mean_intensity;
		logic [15:0] point_total;
		logic        done_res;
	} result_t;

	// result when a drain finds no occupied bucket
	localparam result_t ResDone = '{
		valid_res:      1'b0,
		mean_x:         32'd0,
		mean_y:         32'd0,
		mean_z:         32'd0,
		mean_intensity: 16'd0,
		point_total:    16'd0,
		done_res:       1'b1
	};

	// queue entry: classified item with its bucket
	typedef struct packed {
		logic              op;
		logic [TblAw-1:0]  bucket;
		logic [31:0]       x_coord;
		logic [31:0]       y_coord;
		logic [31:0]       z_coord;
		logic [15:0]       intensity_in;
	} qent_t;

	typedef struct packed {
		logic [47:0] sum_x;
		logic [47:0] sum_y;
		logic [47:0] sum_z;
		logic [31:0] sum_i;
		logic [15:0] cnt;
	} bucket_t;

endpackage

>>> rtl/vhcd_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module vhcd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/vhcd_queue.sv
`timescale 1ns / 1ps
// short fifo between the hashing front and the bucket back end
// depends on vhcd_pkg
module vhcd_queue
	import vhcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  qent_t        wdata,
	input  logic         pop,
	output qent_t        rdata,
	output logic         empty,
	output logic [QAw:0] cnt
);
	qent_t          ent_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, pop};
		end
	end

	assign rdata = ent_q[rd_q];
	assign empty = (cnt_q == '0);
	assign cnt   = cnt_q;
endmodule

>>> rtl/vhcd_front.sv
`timescale 1ns / 1ps
// front end: config registers, voxel scaling and spatial hash pipeline
// depends on vhcd_pkg
module vhcd_front
	import vhcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [23:0]  cfg_data,
	input  logic         accept,
	input  item_t        item,
	input  logic         clearing,
	input  logic [QAw:0] q_cnt,
	output logic         busy,
	output logic         push,
	output qent_t        push_data
);
	logic [23:0] inv_x_q, inv_y_q, inv_z_q;

	logic               s1_v_q, s2_v_q;
	item_t              it_s1, it_s2;
	logic signed [56:0] px_s1, py_s1, pz_s1;
	logic [31:0]        vx_s2, vy_s2, vz_s2;
	logic [31:0]        hash;
	logic [QAw+1:0]     pending;

	function automatic logic [31:0] vox(input logic signed [56:0] p);
		logic signed [56:0] b;
		b = p + (p[56] ? 57'sh0_FFFF_FFFF : 57'sd0);
		return {{7{b[56]}}, b[56:32]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= InvLeafRst;
			inv_y_q <= InvLeafRst;
			inv_z_q <= InvLeafRst;
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CfgInvX: inv_x_q <= cfg_data;
					CfgInvY: inv_y_q <= cfg_data;
					CfgInvZ: inv_z_q <= cfg_data;
					default: ;
				endcase
			end
			s1_v_q <= accept;
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= item;
		px_s1 <= $signed(item.x_coord) * $signed({1'b0, inv_x_q});
		py_s1 <= $signed(item.y_coord) * $signed({1'b0, inv_y_q});
		pz_s1 <= $signed(item.z_coord) * $signed({1'b0, inv_z_q});
		it_s2 <= it_s1;
		vx_s2 <= vox(px_s1);
		vy_s2 <= vox(py_s1);
		vz_s2 <= vox(pz_s1);
	end

	assign hash = (vx_s2 * HashPx) ^ (vy_s2 * HashPy) ^ (vz_s2 * HashPz);

	assign push                   = s2_v_q;
	assign push_data.op           = it_s2.op;
	assign push_data.bucket       = hash[TblAw-1:0];
	assign push_data.x_coord      = it_s2.x_coord;
	assign push_data.y_coord      = it_s2.y_coord;
	assign push_data.z_coord      = it_s2.z_coord;
	assign push_data.intensity_in = it_s2.intensity_in;

	// items in the pipe or queue must never exceed the queue depth
	assign pending = {1'b0, q_cnt} + {{(QAw+1){1'b0}}, s1_v_q} + {{(QAw+1){1'b0}}, s2_v_q};
	assign busy    = clearing || (pending >= (QAw+2)'(QDepth));
endmodule

>>> rtl/vhcd_div.sv
`timescale 1ns / 1ps
// four-lane restoring divider, one quotient bit per cycle, shared divisor
// depends on vhcd_pkg
module vhcd_div
	import vhcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dvd [4],
	input  logic [15:0] dvs,
	output logic        done,
	output logic [47:0] quo [4]
);
	localparam int CntW = $clog2(DivSteps + 1);

	logic            run_q, done_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0]     dvs_q;
	logic [47:0]     quo_q [4];
	logic [16:0]     rem_q [4];
	logic [16:0]     rsh   [4];
	logic [16:0]     rnx   [4];
	logic            qb    [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rsh[i] = {rem_q[i][15:0], quo_q[i][47]};
			qb[i]  = (rsh[i] >= {1'b0, dvs_q});
			rnx[i] = qb[i] ? rsh[i] - {1'b0, dvs_q} : rsh[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= dvs;
			for (int i = 0; i < 4; i++) begin
				quo_q[i] <= dvd[i];
				rem_q[i] <= '0;
			end
		end else if (run_q) begin
			for (int i = 0; i < 4; i++) begin
				quo_q[i] <= {quo_q[i][46:0], qb[i]};
				rem_q[i] <= rnx[i];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

>>> rtl/vhcd_back.sv
`timescale 1ns / 1ps
// back end: bucket accumulate, drain scan, centroid divide and table clear
// depends on vhcd_pkg, vhcd_ram, vhcd_div
module vhcd_back
	import vhcd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  qent_t   q_head,
	output logic    q_pop,
	output logic    clearing,
	output logic    res_valid,
	output result_t res
);
	typedef enum logic [2:0] {
		StClear, StIdle, StAddWr, StScan, StDiv, StEmit
	} state_t;

	state_t            st_q;
	qent_t             ent_q;
	logic [TblAw-1:0]  clr_q, ptr_q, scan_n_q;
	logic [15:0]       cnt_q;
	logic [2:0]        neg_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              we;
	logic [TblAw-1:0]  waddr, raddr;
	bucket_t           wdata, rd;
	logic [191:0]      rdata_raw;
	logic              div_start, div_done;
	logic [47:0]       dvd [4];
	logic [47:0]       quo [4];
	logic [31:0]       qx, qy, qz;

	function automatic logic [47:0] mag(input logic [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

	function automatic logic [31:0] fix(input logic [47:0] q, input logic n);
		return n ? (~q[31:0] + 32'd1) : q[31:0];
	endfunction

	assign rd = bucket_t'(rdata_raw);

	vhcd_ram #(.Width($bits(bucket_t)), .Depth(TblSize)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign dvd[0] = mag(rd.sum_x);
	assign dvd[1] = mag(rd.sum_y);
	assign dvd[2] = mag(rd.sum_z);
	assign dvd[3] = {16'd0, rd.sum_i};
	assign div_start = (st_q == StScan) && (rd.cnt != '0);

	vhcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (dvd),
		.dvs    (rd.cnt),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		q_pop = (st_q == StIdle) && !q_empty;
		raddr = ptr_q;
		case (st_q)
			StIdle:  raddr = (q_head.op == OpAdd) ? q_head.bucket : ptr_q;
			StScan:  raddr = ptr_q + 1'b1;
			default: raddr = ptr_q;
		endcase
		we    = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		case (st_q)
			StClear: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			StAddWr: begin
				we          = (rd.cnt != CountMax);
				waddr       = ent_q.bucket;
				wdata.sum_x = rd.sum_x + {{16{ent_q.x_coord[31]}}, ent_q.x_coord};
				wdata.sum_y = rd.sum_y + {{16{ent_q.y_coord[31]}}, ent_q.y_coord};
				wdata.sum_z = rd.sum_z + {{16{ent_q.z_coord[31]}}, ent_q.z_coord};
				wdata.sum_i = rd.sum_i + {16'd0, ent_q.intensity_in};
				wdata.cnt   = rd.cnt + 16'd1;
			end
			StEmit: begin
				we = 1'b1;
			end
			default: ;
		endcase
	end

	assign qx = fix(quo[0], neg_q[0]);
	assign qy = fix(quo[1], neg_q[1]);
	assign qz = fix(quo[2], neg_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= StClear;
			clr_q       <= '0;
			ptr_q       <= '0;
			scan_n_q    <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			ent_q       <= '0;
			cnt_q       <= '0;
			neg_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (st_q)
				StClear: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TblAw'(TblSize - 1)) st_q <= StIdle;
				end
				StIdle: begin
					if (!q_empty) begin
						ent_q    <= q_head;
						scan_n_q <= '0;
						st_q     <= (q_head.op == OpAdd) ? StAddWr : StScan;
					end
				end
				StAddWr: st_q <= StIdle;
				StScan: begin
					if (rd.cnt != '0) begin
						cnt_q <= rd.cnt;
						neg_q <= {rd.sum_z[47], rd.sum_y[47], rd.sum_x[47]};
						st_q  <= StDiv;
					end else if (scan_n_q == TblAw'(TblSize - 1)) begin
						res_q       <= ResDone;
						res_valid_q <= 1'b1;
						ptr_q       <= '0;
						st_q        <= StIdle;
					end else begin
						ptr_q    <= ptr_q + 1'b1;
						scan_n_q <= scan_n_q + 1'b1;
					end
				end
				StDiv: if (div_done) st_q <= StEmit;
				StEmit: begin
					res_q.valid_res      <= 1'b1;
					res_q.mean_x         <= qx;
					res_q.mean_y         <= qy;
					res_q.mean_z         <= qz;
					res_q.mean_intensity <= quo[3][15:0];
					res_q.point_total    <= cnt_q;
					res_q.done_res       <= 1'b0;
					res_valid_q          <= 1'b1;
					ptr_q                <= ptr_q + 1'b1;
					st_q                 <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign clearing  = (st_q == StClear);
	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

>>> rtl/voxel_hash_centroid_downsampler.sv
`timescale 1ns / 1ps
// top level of the voxel hash centroid downsampler
// depends on vhcd_pkg, vhcd_front, vhcd_queue, vhcd_back
//
// Points (op add) are scaled by the inverse leaf sizes, hashed into one of
// 1024 buckets and summed there; a drain (op drain) emits the mean of the
// next occupied bucket and clears it, or a done result when none is left.
// An item transfers when start is high and busy is low. After reset the
// table is swept to zero with busy held high. A two stage hash pipe
// feeds a four entry queue; the back end takes an add as a bucket read
// then a write back through the ram's separate read and write ports. A
// drain inspects buckets in turn and, on an occupied one, runs the 48
// step divider. Each result shows on res with res_valid high for one
// cycle; the receiver cannot stall it.
module voxel_hash_centroid_downsampler
	import vhcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        res_valid,
	output result_t     res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_data
);
	// handshake and queue wiring
	logic         accept;
	logic         clearing;
	logic         push, pop, q_empty;
	qent_t        push_data, q_head;
	logic [QAw:0] q_cnt;

	// an item transfers only when the front has room
	assign accept = start && !busy;

	// front: hashing pipe and config registers
	vhcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.clearing  (clearing),
		.q_cnt     (q_cnt),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	vhcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (q_head),
		.empty  (q_empty),
		.cnt    (q_cnt)
	);

	// back: bucket table, drain scan and divider
	vhcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (pop),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res       (res)
	);
endmodule
